FILE: rtl/vrl_pkg.sv
package vrl_pkg;

   localparam int COMP_WIDTH_DEF = 32;
   // fraction bits kept in the magnitude root
   localparam int SQRT_FRAC = 16;
   // per-request flags: [0] x negative, [1] y negative, [2] z negative, [3] zero vector
   localparam int FLAG_W = 4;
   localparam int FLAG_ZERO = 3;

endpackage

FILE: rtl/vector_rescale_to_length_core.sv
// Rescales a signed fixed-point 3D vector to |target_length|. Fully pipelined:
// one request per cycle, through three rows of one-bit-per-cycle cells:
// COMP_WIDTH shift-add cells for the squares and products, COMP_WIDTH+SQRT_FRAC
// square-root digit cells, and COMP_WIDTH+1 divider cells. The whole row stalls
// while a result waits on rsp_tready. A zero vector returns zeros with
// zero_vector set; results beyond the signed range clamp and set saturated.
module vector_rescale_to_length_core
   import vrl_pkg::*;
#(
   parameter int  COMP_WIDTH = COMP_WIDTH_DEF,
   localparam int REQ_W      = ((4 * COMP_WIDTH + 7) / 8) * 8,
   localparam int RSP_W      = ((3 * COMP_WIDTH + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,  // comp_x, comp_y, comp_z, target_length
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,  // res_x, res_y, res_z
   output logic [1:0]       rsp_tuser   // zero_vector, saturated
);

   localparam int W      = COMP_WIDTH;
   localparam int RW     = W + SQRT_FRAC;
   localparam int QW     = W + 1;
   localparam int SSIDE  = 6 * W + FLAG_W;
   localparam int DSIDE  = FLAG_W + 3;
   localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
   localparam logic [W+1:0] NEG_LIM = {3'b001, {(W-1){1'b0}}};

   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // ---------------- squares and products ----------------
   logic                mv    [W+1];
   logic [3:0][W-1:0]   mmag  [W+1];
   logic [FLAG_W-1:0]   mflag [W+1];
   logic [2:0][2*W-1:0] msq   [W+1];
   logic [2:0][2*W-1:0] mpr   [W+1];
   logic [3:0][W-1:0]   raw;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         raw[i]     = req_tdata[i*W +: W];
         mmag[0][i] = raw[i][W-1] ? (~raw[i] + W'(1)) : raw[i];
      end
      mflag[0] = {(raw[0] == '0) && (raw[1] == '0) && (raw[2] == '0),
                  raw[2][W-1], raw[1][W-1], raw[0][W-1]};
   end

   assign mv[0]  = req_tvalid;
   assign msq[0] = '0;
   assign mpr[0] = '0;

   for (genvar g = 0; g < W; g++) begin : g_mul
      vrl_mul_cell #(.W(W), .STEP(g)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .valid_i (mv[g]),
         .mag_i   (mmag[g]),
         .flag_i  (mflag[g]),
         .sq_i    (msq[g]),
         .pr_i    (mpr[g]),
         .valid_o (mv[g+1]),
         .mag_o   (mmag[g+1]),
         .flag_o  (mflag[g+1]),
         .sq_o    (msq[g+1]),
         .pr_o    (mpr[g+1])
      );
   end

   // ---------------- magnitude squared ----------------
   logic             sum_valid_ff;
   logic [2*W-1:0]   sum_ff;
   logic [SSIDE-1:0] sum_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else if (adv) begin
         sum_valid_ff <= mv[W];
      end
   end

   // sum of three squares stays below 2^(2W)
   always_ff @(posedge clock) begin
      if (adv) begin
         sum_ff      <= msq[W][0] + msq[W][1] + msq[W][2];
         sum_side_ff <= {mflag[W], mpr[W][2], mpr[W][1], mpr[W][0]};
      end
   end

   // ---------------- square root ----------------
   logic             sv    [RW+1];
   logic [2*RW-1:0]  srad  [RW+1];
   logic [RW+1:0]    srem  [RW+1];
   logic [RW-1:0]    sroot [RW+1];
   logic [SSIDE-1:0] sside [RW+1];

   assign sv[0]    = sum_valid_ff;
   assign srad[0]  = {sum_ff, {(2*SQRT_FRAC){1'b0}}};
   assign srem[0]  = '0;
   assign sroot[0] = '0;
   assign sside[0] = sum_side_ff;

   for (genvar g = 0; g < RW; g++) begin : g_sqrt
      vrl_sqrt_cell #(.RW(RW), .SIDE_W(SSIDE)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .valid_i (sv[g]),
         .rad_i   (srad[g]),
         .rem_i   (srem[g]),
         .root_i  (sroot[g]),
         .side_i  (sside[g]),
         .valid_o (sv[g+1]),
         .rad_o   (srad[g+1]),
         .rem_o   (srem[g+1]),
         .root_o  (sroot[g+1]),
         .side_o  (sside[g+1])
      );
   end

   // ---------------- division ----------------
   logic               dv    [QW+1];
   logic [2:0][RW-1:0] drem  [QW+1];
   logic [2:0][QW-1:0] dlow  [QW+1];
   logic [RW-1:0]      droot [QW+1];
   logic [DSIDE-1:0]   dside [QW+1];
   logic [2:0]         ovf;
   logic [2*W+SQRT_FRAC-1:0] num;

   // quotient is kept to QW bits; a high part already >= root means overflow
   always_comb begin
      droot[0] = (sroot[RW] == '0) ? RW'(1) : sroot[RW];
      num      = '0;
      for (int c = 0; c < 3; c++) begin
         num        = {sside[RW][c*2*W +: 2*W], {SQRT_FRAC{1'b0}}};
         drem[0][c] = {1'b0, num[2*W+SQRT_FRAC-1 -: RW-1]};
         dlow[0][c] = num[QW-1:0];
         ovf[c]     = (drem[0][c] >= droot[0]);
      end
      dside[0] = {sside[RW][SSIDE-1 -: FLAG_W], ovf};
   end

   assign dv[0] = sv[RW];

   for (genvar g = 0; g < QW; g++) begin : g_div
      vrl_div_cell #(.RW(RW), .QW(QW), .SIDE_W(DSIDE)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .valid_i (dv[g]),
         .rem_i   (drem[g]),
         .low_i   (dlow[g]),
         .root_i  (droot[g]),
         .side_i  (dside[g]),
         .valid_o (dv[g+1]),
         .rem_o   (drem[g+1]),
         .low_o   (dlow[g+1]),
         .root_o  (droot[g+1]),
         .side_o  (dside[g+1])
      );
   end

   // ---------------- sign, clamp, output register ----------------
   logic               rsp_valid_ff;
   logic [2:0][W-1:0]  res_ff, res_in;
   logic               zero_ff, sat_ff, sat_in, zero_in;
   logic [W+1:0]       qc;
   logic               csat, neg;
   logic [DSIDE-1:0]   fs;

   always_comb begin
      fs      = dside[QW];
      zero_in = fs[3 + FLAG_ZERO];
      sat_in  = 1'b0;
      qc      = '0;
      csat    = 1'b0;
      neg     = 1'b0;
      for (int c = 0; c < 3; c++) begin
         neg = fs[3 + c];
         qc  = {1'b0, dlow[QW][c]} + {{(W+1){1'b0}}, (drem[QW][c] != '0)};
         if (!neg) begin
            csat      = fs[c] || dlow[QW][c][W] || dlow[QW][c][W-1];
            res_in[c] = csat ? MAXV : dlow[QW][c][W-1:0];
         end else begin
            csat      = fs[c] || (qc > NEG_LIM);
            res_in[c] = csat ? MINV : (~qc[W-1:0] + W'(1));
         end
         if (zero_in) begin
            res_in[c] = '0;
            csat      = 1'b0;
         end
         sat_in = sat_in || csat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv && dv[QW]) begin
         res_ff  <= res_in;
         zero_ff <= zero_in;
         sat_ff  <= sat_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({res_ff[2], res_ff[1], res_ff[0]});
   assign rsp_tuser  = {sat_ff, zero_ff};

   // ---------------- checks ----------------
   a_zero_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && zero_ff |-> !sat_ff && res_ff == '0)
      else $error("zero vector result not clean");

   a_sat_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && sat_ff |->
         res_ff[0] == MAXV || res_ff[0] == MINV || res_ff[1] == MAXV ||
         res_ff[1] == MINV || res_ff[2] == MAXV || res_ff[2] == MINV)
      else $error("saturated flag without a clamped component");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(dv[QW]) && $stable(sv[RW]))
      else $error("pipeline moved while output stalled");

endmodule

FILE: rtl/vrl_mul_cell.sv
// One shift-and-add step: adds bit STEP of the multiplier into the three
// squares and the three component-by-length products.
module vrl_mul_cell
   import vrl_pkg::*;
#(
   parameter int W    = COMP_WIDTH_DEF,
   parameter int STEP = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic                    valid_i,
   input  logic [3:0][W-1:0]       mag_i,    // x, y, z, length
   input  logic [FLAG_W-1:0]       flag_i,
   input  logic [2:0][2*W-1:0]     sq_i,
   input  logic [2:0][2*W-1:0]     pr_i,
   output logic                    valid_o,
   output logic [3:0][W-1:0]       mag_o,
   output logic [FLAG_W-1:0]       flag_o,
   output logic [2:0][2*W-1:0]     sq_o,
   output logic [2:0][2*W-1:0]     pr_o
);

   logic                valid_ff;
   logic [3:0][W-1:0]   mag_ff;
   logic [FLAG_W-1:0]   flag_ff;
   logic [2:0][2*W-1:0] sq_ff, sq_in;
   logic [2:0][2*W-1:0] pr_ff, pr_in;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sq_in[c] = sq_i[c] + (mag_i[c][STEP] ? ({{W{1'b0}}, mag_i[c]} << STEP) : '0);
         pr_in[c] = pr_i[c] + (mag_i[3][STEP] ? ({{W{1'b0}}, mag_i[c]} << STEP) : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mag_ff  <= mag_i;
         flag_ff <= flag_i;
         sq_ff   <= sq_in;
         pr_ff   <= pr_in;
      end
   end

   assign valid_o = valid_ff;
   assign mag_o   = mag_ff;
   assign flag_o  = flag_ff;
   assign sq_o    = sq_ff;
   assign pr_o    = pr_ff;

endmodule

FILE: rtl/vrl_sqrt_cell.sv
// One digit of the integer square root: takes two radicand bits,
// yields one root bit.
module vrl_sqrt_cell
   import vrl_pkg::*;
#(
   parameter int RW     = COMP_WIDTH_DEF + SQRT_FRAC,
   parameter int SIDE_W = 6 * COMP_WIDTH_DEF + FLAG_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              valid_i,
   input  logic [2*RW-1:0]   rad_i,
   input  logic [RW+1:0]     rem_i,
   input  logic [RW-1:0]     root_i,
   input  logic [SIDE_W-1:0] side_i,
   output logic              valid_o,
   output logic [2*RW-1:0]   rad_o,
   output logic [RW+1:0]     rem_o,
   output logic [RW-1:0]     root_o,
   output logic [SIDE_W-1:0] side_o
);

   logic              valid_ff;
   logic [2*RW-1:0]   rad_ff;
   logic [RW+1:0]     rem_ff, rem_in;
   logic [RW-1:0]     root_ff, root_in;
   logic [SIDE_W-1:0] side_ff;
   logic [RW+3:0]     rem_x, trial, diff;
   logic              ge;

   always_comb begin
      rem_x   = {rem_i, rad_i[2*RW-1 -: 2]};
      trial   = {2'b00, root_i, 2'b01};
      ge      = (rem_x >= trial);
      diff    = rem_x - trial;
      rem_in  = ge ? diff[RW+1:0] : rem_x[RW+1:0];
      root_in = {root_i[RW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rad_ff  <= {rad_i[2*RW-3:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= root_in;
         side_ff <= side_i;
      end
   end

   assign valid_o = valid_ff;
   assign rad_o   = rad_ff;
   assign rem_o   = rem_ff;
   assign root_o  = root_ff;
   assign side_o  = side_ff;

endmodule

FILE: rtl/vrl_div_cell.sv
// One restoring division step for all three components; quotient bits
// shift in at the bottom of the dividend word as its bits are used up.
module vrl_div_cell
   import vrl_pkg::*;
#(
   parameter int RW     = COMP_WIDTH_DEF + SQRT_FRAC,
   parameter int QW     = COMP_WIDTH_DEF + 1,
   parameter int SIDE_W = FLAG_W + 3
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                valid_i,
   input  logic [2:0][RW-1:0]  rem_i,
   input  logic [2:0][QW-1:0]  low_i,
   input  logic [RW-1:0]       root_i,
   input  logic [SIDE_W-1:0]   side_i,
   output logic                valid_o,
   output logic [2:0][RW-1:0]  rem_o,
   output logic [2:0][QW-1:0]  low_o,
   output logic [RW-1:0]       root_o,
   output logic [SIDE_W-1:0]   side_o
);

   logic               valid_ff;
   logic [2:0][RW-1:0] rem_ff, rem_in;
   logic [2:0][QW-1:0] low_ff, low_in;
   logic [RW-1:0]      root_ff;
   logic [SIDE_W-1:0]  side_ff;
   logic [RW:0]        t, d;
   logic               ge;

   always_comb begin
      t  = '0;
      d  = '0;
      ge = 1'b0;
      for (int c = 0; c < 3; c++) begin
         t         = {rem_i[c], low_i[c][QW-1]};
         ge        = (t >= {1'b0, root_i});
         d         = t - {1'b0, root_i};
         rem_in[c] = ge ? d[RW-1:0] : t[RW-1:0];
         low_in[c] = {low_i[c][QW-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff  <= rem_in;
         low_ff  <= low_in;
         root_ff <= root_i;
         side_ff <= side_i;
      end
   end

   assign valid_o = valid_ff;
   assign rem_o   = rem_ff;
   assign low_o   = low_ff;
   assign root_o  = root_ff;
   assign side_o  = side_ff;

endmodule
